### src/priority_rectangle_hit_test_unit_defines.svh
// Assertion macros used by the hit test unit top level.
`ifndef PRIORITY_RECTANGLE_HIT_TEST_UNIT_DEFINES_SVH
`define PRIORITY_RECTANGLE_HIT_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PRHTU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PRHTU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/prhtu_pkg.sv
// Shared types and constants of the rectangle hit test unit.
`timescale 1ns / 1ps

package prhtu_pkg;

	localparam int SLOT_BITS  = 4;
	localparam int LEVEL_BITS = 8;

	// tuser codes of the input stream
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// result transaction, hit in the lowest bit
	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic [SLOT_BITS-1:0]  slot;
		logic                  hit;
	} hit_result_t;

	localparam int RESULT_BITS   = $bits(hit_result_t);
	localparam int OUT_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

### src/prhtu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module prhtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/priority_rectangle_hit_test_unit.sv
// Top level of the priority rectangle hit test unit.
`timescale 1ns / 1ps

// Rectangle table with a priority point query. A write transaction (tuser = 0) stores a
// rectangle and level in one slot, or clears the slot's valid mark. A query transaction
// (tuser = 1) walks the table through the RAM read port with one shared comparator, one
// slot per cycle, and the input stays not ready from the taking of the query until the scan
// is done and the previous result, if any, has been taken. The result names the
// highest-level valid rectangle that strictly holds the point, lowest slot on ties, with
// slot and level zero on a miss. Valid marks clear at reset; bounds and levels are not
// initialized.
module priority_rectangle_hit_test_unit #(
	parameter int NUM_SLOTS  = 16,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// fields from bit 0: slot, slot_enable, rect_left, rect_top, rect_right,
	// rect_bottom, rect_level, query_x, query_y, zero fill
	input  logic [((13 + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// fields from bit 0: kind
	input  logic                                   s_tuser,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// fields from bit 0: hit, hit_slot, hit_level, zero fill
	output logic [prhtu_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready
);

	import prhtu_pkg::*;

	`include "priority_rectangle_hit_test_unit_defines.svh"

	localparam int CB = COORD_BITS;
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int EW = SLOT_BITS + IW;
	localparam int RAM_W = 4 * CB + LEVEL_BITS;

	// input field offsets
	localparam int OFF_EN  = SLOT_BITS;
	localparam int OFF_L   = OFF_EN + 1;
	localparam int OFF_T   = OFF_L + CB;
	localparam int OFF_R   = OFF_T + CB;
	localparam int OFF_B   = OFF_R + CB;
	localparam int OFF_LVL = OFF_B + CB;
	localparam int OFF_X   = OFF_LVL + LEVEL_BITS;
	localparam int OFF_Y   = OFF_X + CB;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [NUM_SLOTS-1:0]  valid_q;
	logic [IW-1:0]         cmp_idx_q;
	logic signed [CB-1:0]  qx_q;
	logic signed [CB-1:0]  qy_q;
	logic                  found_q;
	logic [SLOT_BITS-1:0]  best_slot_q;
	logic [LEVEL_BITS-1:0] best_level_q;
	logic                  m_tvalid_q;
	hit_result_t           result_q;

	logic                  in_acc;
	logic                  wr_acc;
	logic                  qry_acc;
	logic [EW-1:0]         slot_ext;
	logic [IW-1:0]         wr_idx;
	logic                  slot_in_range;
	logic                  wr_en;
	logic [RAM_W-1:0]      wr_word;
	logic [IW-1:0]         rd_addr;
	logic [RAM_W-1:0]      rd_word;
	logic                  last_slot;
	logic                  out_free;

	logic signed [CB-1:0]  e_left;
	logic signed [CB-1:0]  e_top;
	logic signed [CB-1:0]  e_right;
	logic signed [CB-1:0]  e_bottom;
	logic [LEVEL_BITS-1:0] e_level;
	logic                  e_hit;
	logic                  e_wins;

	// input handshake and write decode
	assign s_tready      = (state_q == ST_IDLE);
	assign in_acc        = s_tvalid & s_tready;
	assign wr_acc        = in_acc & (s_tuser == KIND_WRITE);
	assign qry_acc       = in_acc & (s_tuser == KIND_QUERY);
	assign slot_ext      = {{IW{1'b0}}, s_tdata[SLOT_BITS-1:0]};
	assign wr_idx        = slot_ext[IW-1:0];
	assign slot_in_range = (slot_ext < EW'(NUM_SLOTS));
	assign wr_en         = wr_acc & slot_in_range & s_tdata[OFF_EN];
	assign wr_word       = s_tdata[OFF_X-1:OFF_L];

	// read address runs one slot ahead of the comparator
	assign last_slot = (cmp_idx_q == IW'(NUM_SLOTS - 1));
	assign rd_addr   = (state_q == ST_SCAN && !last_slot) ? cmp_idx_q + 1'b1 : '0;

	prhtu_ram #(
		.WIDTH(RAM_W),
		.DEPTH(NUM_SLOTS)
	) u_rect_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_word),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	// shared compare unit: containment and level against the running best
	assign e_left   = $signed(rd_word[CB-1:0]);
	assign e_top    = $signed(rd_word[2*CB-1:CB]);
	assign e_right  = $signed(rd_word[3*CB-1:2*CB]);
	assign e_bottom = $signed(rd_word[4*CB-1:3*CB]);
	assign e_level  = rd_word[RAM_W-1:4*CB];
	assign e_hit    = valid_q[cmp_idx_q] &&
	                  (e_left < qx_q) && (qx_q < e_right) &&
	                  (e_top < qy_q) && (qy_q < e_bottom);
	assign e_wins   = e_hit && (!found_q || (e_level > best_level_q));

	assign out_free = !m_tvalid_q || m_tready;

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_acc && slot_in_range) begin
			valid_q[wr_idx] <= s_tdata[OFF_EN];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmp_idx_q <= '0;
			found_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (qry_acc) begin
						state_q   <= ST_SCAN;
						cmp_idx_q <= '0;
						found_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (e_wins) begin
						found_q <= 1'b1;
					end
					if (last_slot) begin
						state_q <= ST_DONE;
					end else begin
						cmp_idx_q <= cmp_idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// query point and running best
	always_ff @(posedge clk) begin
		if (qry_acc) begin
			qx_q         <= $signed(s_tdata[OFF_Y-1:OFF_X]);
			qy_q         <= $signed(s_tdata[OFF_Y+CB-1:OFF_Y]);
			best_slot_q  <= '0;
			best_level_q <= '0;
		end else if (state_q == ST_SCAN && e_wins) begin
			best_slot_q  <= SLOT_BITS'({{SLOT_BITS{1'b0}}, cmp_idx_q});
			best_level_q <= e_level;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result_q.hit   <= found_q;
			result_q.slot  <= best_slot_q;
			result_q.level <= best_level_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - RESULT_BITS){1'b0}}, result_q};

	// checks
	`PRHTU_ASSERT_NEXT(a_query_starts_scan, qry_acc, (state_q == ST_SCAN) && (cmp_idx_q == '0), "query did not start a scan at slot zero")
	`PRHTU_ASSERT_NEXT(a_scan_ends_done, (state_q == ST_SCAN) && last_slot, state_q == ST_DONE, "scan did not finish after the last slot")
	`PRHTU_ASSERT_NOW(a_miss_is_zero, (state_q == ST_DONE) && !found_q, (best_slot_q == '0) && (best_level_q == '0), "miss carries nonzero slot or level")
	`PRHTU_ASSERT_NEXT(a_write_sets_valid, wr_en, valid_q[$past(wr_idx)], "stored slot not marked valid")

endmodule
